@@ rtl/vmosf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmosf_pkg
// Shared constants for the operand stack with call frames: command and
// status codes, fixed field widths and default parameter values.
// ----------------------------------------------------------------------------
package vmosf_pkg;

    localparam int CMD_BITS    = 4;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 11;
    localparam int LIMIT_BITS  = 11;
    localparam int STATUS_BITS = 2;

    localparam int DEF_STORE_WORDS = 1024;
    localparam int DEF_FRAME_WORDS = 4;
    localparam int DEF_WORD_BITS   = 32;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 11'd1024;

    typedef logic [CMD_BITS-1:0]    t_cmd;
    typedef logic [STATUS_BITS-1:0] t_status;

    localparam t_cmd CMD_PUSH     = 4'd0;
    localparam t_cmd CMD_POP      = 4'd1;
    localparam t_cmd CMD_PEEK     = 4'd2;
    localparam t_cmd CMD_SET_TOP  = 4'd3;
    localparam t_cmd CMD_DUP      = 4'd4;
    localparam t_cmd CMD_DISCARD  = 4'd5;
    localparam t_cmd CMD_ADDRESS  = 4'd6;
    localparam t_cmd CMD_FPUSH    = 4'd7;
    localparam t_cmd CMD_FPOP     = 4'd8;
    localparam t_cmd CMD_SET_FIN  = 4'd9;
    localparam t_cmd CMD_SET_DISC = 4'd10;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_OVER  = 2'd1;
    localparam t_status ST_UNDER = 2'd2;

endpackage

@@ rtl/vm_operand_stack_with_frames.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm_operand_stack_with_frames
// Operand stack of a stack machine with call frames held in one word store.
// ----------------------------------------------------------------------------
// Usage: a request (i_command with i_value, i_count, i_flag_value) is taken
// at a rising edge with start high and busy low. Exactly one result comes
// back on the o_ result ports, marked by a one-cycle o_done strobe; the
// receiver cannot stall it, so it must sample on o_done.
// Request handling, set by the word store with one write port and one
// registered read port:
//   push, set top, discard, address, frame push, flag writes, empty peek,
//   zero dup, unknown codes, failed checks: result in the next cycle, busy
//   stays low, so one request per cycle.
//   pop, peek of a non-empty frame, frame pop: store read, then result; busy high.
//   dup of n entries: busy while one word is copied per cycle, then result.
// Write stack_limit (i_cfg_we/i_cfg_wdata) only while idle; it is not enforced.
// Reset leaves an empty root frame, final flag set, discard flag clear and
// the limit at 1024; the store itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module vm_operand_stack_with_frames #(
    parameter int STORE_WORDS = vmosf_pkg::DEF_STORE_WORDS,
    parameter int FRAME_WORDS = vmosf_pkg::DEF_FRAME_WORDS,
    parameter int WORD_BITS   = vmosf_pkg::DEF_WORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [vmosf_pkg::CMD_BITS-1:0]     i_command,
    input  logic [vmosf_pkg::VALUE_BITS-1:0]   i_value,
    input  logic [vmosf_pkg::COUNT_BITS-1:0]   i_count,
    input  logic                               i_flag_value,
    input  logic                               i_cfg_we,
    input  logic [vmosf_pkg::LIMIT_BITS-1:0]   i_cfg_wdata,
    output logic                               o_done,
    output logic [vmosf_pkg::STATUS_BITS-1:0]  o_status,
    output logic [vmosf_pkg::VALUE_BITS-1:0]   o_read_value,
    output logic                               o_found,
    output logic [vmosf_pkg::COUNT_BITS-1:0]   o_entry_address,
    output logic                               o_final_flag,
    output logic                               o_discard_flag
);

    localparam int AW  = $clog2(STORE_WORDS);
    localparam int VB  = vmosf_pkg::VALUE_BITS;
    localparam int CB  = vmosf_pkg::COUNT_BITS;
    localparam int XW  = ((AW + 1 > CB) ? AW + 1 : CB) + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DUP  = 2'd2;

    localparam logic [XW-1:0] STORE_X = XW'(STORE_WORDS);
    localparam logic [XW-1:0] FRAME_X = XW'(FRAME_WORDS);

    // word store
    logic [WORD_BITS-1:0] mem [STORE_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // control state
    logic [1:0]                       r_state, n_state;
    logic [AW-1:0]                    r_top, n_top;
    logic [AW-1:0]                    r_base, n_base;
    logic                             r_final, n_final;
    logic                             r_disc, n_disc;
    logic [vmosf_pkg::LIMIT_BITS-1:0] r_limit;
    vmosf_pkg::t_cmd                  r_cmd, n_cmd;
    logic [AW-1:0]                    r_src, n_src;
    logic [AW-1:0]                    r_dst, n_dst;
    logic [CB-1:0]                    r_left, n_left;

    // result registers
    logic                  r_done, n_done;
    vmosf_pkg::t_status    r_status, n_status;
    logic [VB-1:0]         r_rv, n_rv;
    logic                  r_found, n_found;
    logic [CB-1:0]         r_addr, n_addr;

    // checks on the current state
    logic [XW-1:0]        top_x, base_x, lim_x, cnt_x, len_x, hdr_x, nb_x;
    logic [WORD_BITS+15:0] hdr_ext;
    logic                  accept;

    assign accept = start && (r_state == S_IDLE);

    always_comb begin
        top_x   = XW'(r_top);
        base_x  = XW'(r_base);
        cnt_x   = XW'(i_count);
        lim_x   = (XW'(r_limit) < STORE_X) ? XW'(r_limit) : STORE_X;
        len_x   = (top_x + 1'b1 >= base_x) ? top_x + 1'b1 - base_x : '0;
        hdr_x   = top_x + 1'b1;
        nb_x    = hdr_x + FRAME_X;
        hdr_ext = {16'b0, r_rdata};
    end

    always_comb begin
        n_state   = r_state;
        n_top     = r_top;
        n_base    = r_base;
        n_final   = r_final;
        n_disc    = r_disc;
        n_cmd     = r_cmd;
        n_src     = r_src;
        n_dst     = r_dst;
        n_left    = r_left;
        n_done    = 1'b0;
        n_status  = vmosf_pkg::ST_OK;
        n_rv      = '0;
        n_found   = 1'b0;
        n_addr    = '0;
        mem_we    = 1'b0;
        mem_waddr = r_dst;
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_src;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd  = i_command;
                    n_done = 1'b1;
                    case (i_command)
                        vmosf_pkg::CMD_PUSH: begin
                            if (hdr_x >= lim_x) begin
                                n_status = vmosf_pkg::ST_OVER;
                            end else begin
                                n_top     = AW'(hdr_x);
                                mem_we    = 1'b1;
                                mem_waddr = AW'(hdr_x);
                                mem_wdata = WORD_BITS'(i_value);
                            end
                        end
                        vmosf_pkg::CMD_POP: begin
                            if (len_x == '0) begin
                                n_status = vmosf_pkg::ST_UNDER;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_top;
                                n_top     = r_top - 1'b1;
                                n_done    = 1'b0;
                                n_state   = S_READ;
                            end
                        end
                        vmosf_pkg::CMD_PEEK: begin
                            if (len_x != '0) begin
                                mem_re    = 1'b1;
                                mem_raddr = r_top;
                                n_done    = 1'b0;
                                n_state   = S_READ;
                            end
                        end
                        vmosf_pkg::CMD_SET_TOP: begin
                            if (len_x == '0) begin
                                n_status = vmosf_pkg::ST_UNDER;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_top;
                                mem_wdata = WORD_BITS'(i_value);
                            end
                        end
                        vmosf_pkg::CMD_DUP: begin
                            // a single-entry dup checks underflow first
                            if (i_count == CB'(1) && len_x == '0) begin
                                n_status = vmosf_pkg::ST_UNDER;
                            end else if (top_x + cnt_x >= lim_x) begin
                                n_status = vmosf_pkg::ST_OVER;
                            end else if (len_x < cnt_x) begin
                                n_status = vmosf_pkg::ST_UNDER;
                            end else if (i_count != '0) begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(hdr_x - cnt_x);
                                n_src     = AW'(hdr_x - cnt_x + 1'b1);
                                n_dst     = AW'(hdr_x);
                                n_left    = i_count;
                                n_top     = AW'(top_x + cnt_x);
                                n_done    = 1'b0;
                                n_state   = S_DUP;
                            end
                        end
                        vmosf_pkg::CMD_DISCARD: begin
                            if (len_x < cnt_x) begin
                                n_status = vmosf_pkg::ST_UNDER;
                            end else begin
                                n_top = AW'(top_x - cnt_x);
                            end
                        end
                        vmosf_pkg::CMD_ADDRESS: begin
                            if (len_x < cnt_x) begin
                                n_status = vmosf_pkg::ST_UNDER;
                            end else begin
                                n_addr = CB'(hdr_x - cnt_x);
                            end
                        end
                        vmosf_pkg::CMD_FPUSH: begin
                            if (hdr_x >= lim_x || nb_x >= lim_x) begin
                                n_status = vmosf_pkg::ST_OVER;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(hdr_x);
                                mem_wdata = WORD_BITS'({base_x, r_disc, r_final});
                                n_base    = AW'(nb_x);
                                n_top     = AW'(nb_x - 1'b1);
                                n_final   = 1'b0;
                                n_disc    = 1'b0;
                            end
                        end
                        vmosf_pkg::CMD_FPOP: begin
                            if (base_x <= FRAME_X) begin
                                n_status = vmosf_pkg::ST_UNDER;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(base_x - FRAME_X);
                                n_dst     = AW'(base_x - FRAME_X);
                                n_top     = AW'(base_x - FRAME_X - 1'b1);
                                n_done    = 1'b0;
                                n_state   = S_READ;
                            end
                        end
                        vmosf_pkg::CMD_SET_FIN: begin
                            n_final = i_flag_value;
                        end
                        vmosf_pkg::CMD_SET_DISC: begin
                            n_disc = i_flag_value;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_cmd == vmosf_pkg::CMD_FPOP) begin
                    // restore the caller and release the header word
                    mem_we    = 1'b1;
                    mem_waddr = r_dst;
                    mem_wdata = '0;
                    n_base    = AW'(hdr_ext[17:2]);
                    n_final   = r_rdata[0];
                    n_disc    = r_rdata[1];
                end else begin
                    n_rv    = VB'(r_rdata);
                    n_found = (r_cmd == vmosf_pkg::CMD_PEEK);
                end
            end
            S_DUP: begin
                // write the word read last cycle, fetch the next one if any remain
                mem_we = 1'b1;
                n_dst  = r_dst + 1'b1;
                if (r_left == CB'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem_re = 1'b1;
                    n_src  = r_src + 1'b1;
                    n_left = r_left - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= AW'(FRAME_WORDS - 1);
            r_base  <= AW'(FRAME_WORDS);
            r_final <= 1'b1;
            r_disc  <= 1'b0;
            r_limit <= vmosf_pkg::LIMIT_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_base  <= n_base;
            r_final <= n_final;
            r_disc  <= n_disc;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_left   <= n_left;
        r_status <= n_status;
        r_rv     <= n_rv;
        r_found  <= n_found;
        r_addr   <= n_addr;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_read_value     = r_rv;
    assign o_found          = r_found;
    assign o_entry_address  = r_addr;
    assign o_final_flag     = r_final;
    assign o_discard_flag   = r_disc;

    // between requests the top never drops below the word under the frame's base
    a_frame_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> XW'(r_top) + 1'b1 >= XW'(r_base))
        else $error("top below frame base");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe while busy");

    a_dup_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUP && r_left == CB'(1)) |=> (r_done && r_state == S_IDLE))
        else $error("dup copy did not finish");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == vmosf_pkg::CMD_POP && len_x == '0)
        |=> (r_done && r_status == vmosf_pkg::ST_UNDER))
        else $error("pop of empty frame not flagged");

endmodule

@@ dv/vm_operand_stack_with_frames_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm_operand_stack_with_frames_tb
// Self-checking bench for the operand stack with call frames. A table of
// corner requests runs first. Random request streams follow under several
// stack limits, the extremes among them. Every result is compared field by
// field with a fixed result or an untimed model of the stack, its frames and flags.
// ----------------------------------------------------------------------------
module vm_operand_stack_with_frames_tb;

    localparam int STORE_WORDS = vmosf_pkg::DEF_STORE_WORDS;
    localparam int FRAME_WORDS = vmosf_pkg::DEF_FRAME_WORDS;
    localparam int WORD_BITS   = vmosf_pkg::DEF_WORD_BITS;
    localparam int VALUE_BITS  = vmosf_pkg::VALUE_BITS;
    localparam int COUNT_BITS  = vmosf_pkg::COUNT_BITS;
    localparam int LIMIT_BITS  = vmosf_pkg::LIMIT_BITS;

    // Outside the command map: the block must ignore it and report ok.
    localparam vmosf_pkg::t_cmd CMD_UNKNOWN = 4'd15;

    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 125;
    localparam int DIR_ROWS       = 25;
    localparam int SHOWN_ERRORS   = 40;
    localparam int TIMEOUT_CYCLES = 5_000_000;

    typedef struct packed {
        vmosf_pkg::t_cmd       cmd;
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
        logic                  flag;
    } t_stack_req;

    typedef struct packed {
        vmosf_pkg::t_status    status;
        logic [VALUE_BITS-1:0] read_value;
        logic                  found;
        logic [COUNT_BITS-1:0] entry_address;
        logic                  final_flag;
        logic                  discard_flag;
    } t_stack_res;

    typedef struct packed {
        t_stack_req rq;
        logic       fixed;
        t_stack_res res;
    } t_dir_row;

    // Rows with fixed set carry their result; the rest go through the model.
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{'{vmosf_pkg::CMD_POP,      32'h0,         11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_UNDER, 32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_PEEK,     32'h0,         11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_OK,    32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_SET_TOP,  32'h1234_5678, 11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_UNDER, 32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_DISCARD,  32'h0,         11'd1024, 1'b0}, 1'b1,
          '{vmosf_pkg::ST_UNDER, 32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_DISCARD,  32'h0,         11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_OK,    32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_ADDRESS,  32'h0,         11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_OK,    32'h0, 1'b0, 11'd4, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_DUP,      32'h0,         11'd1,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_UNDER, 32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_DUP,      32'h0,         11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_OK,    32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_DUP,      32'h0,         11'd1024, 1'b0}, 1'b1,
          '{vmosf_pkg::ST_OVER,  32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_FPOP,     32'h0,         11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_UNDER, 32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_PUSH,     32'hFFFF_FFFF, 11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_OK,    32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_PUSH,     32'h0,         11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_OK,    32'h0, 1'b0, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_PEEK,     32'h0,         11'd0,    1'b0}, 1'b1,
          '{vmosf_pkg::ST_OK,    32'h0, 1'b1, 11'd0, 1'b1, 1'b0}},
        '{'{vmosf_pkg::CMD_DUP,      32'h0,         11'd2,    1'b0}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_ADDRESS,  32'h0,         11'd4,    1'b0}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_SET_TOP,  32'hA5A5_5A5A, 11'd0,    1'b0}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_POP,      32'h0,         11'd0,    1'b0}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_FPUSH,    32'h0,         11'd0,    1'b0}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_SET_DISC, 32'h0,         11'd0,    1'b1}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_PUSH,     32'h8000_0001, 11'd0,    1'b0}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_FPUSH,    32'h0,         11'd0,    1'b0}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_SET_FIN,  32'h0,         11'd0,    1'b1}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_FPOP,     32'h0,         11'd0,    1'b0}, 1'b0, '0},
        '{'{vmosf_pkg::CMD_FPOP,     32'h0,         11'd0,    1'b0}, 1'b0, '0},
        '{'{CMD_UNKNOWN,             32'h0,         11'd0,    1'b0}, 1'b0, '0}
    };

    logic                                i_clk;
    logic                                i_rst_n        = 1'b0;
    logic                                start          = 1'b0;
    logic [vmosf_pkg::CMD_BITS-1:0]      i_command      = '0;
    logic [VALUE_BITS-1:0]               i_value        = '0;
    logic [COUNT_BITS-1:0]               i_count        = '0;
    logic                                i_flag_value   = 1'b0;
    logic                                i_cfg_we       = 1'b0;
    logic [LIMIT_BITS-1:0]               i_cfg_wdata    = '0;
    logic                                busy;
    logic                                o_done;
    logic [vmosf_pkg::STATUS_BITS-1:0]   o_status;
    logic [VALUE_BITS-1:0]               o_read_value;
    logic                                o_found;
    logic [COUNT_BITS-1:0]               o_entry_address;
    logic                                o_final_flag;
    logic                                o_discard_flag;

    // Model state of the stack.
    logic [WORD_BITS-1:0]   mirror_words [STORE_WORDS];
    int unsigned            mirror_top     = FRAME_WORDS - 1;
    int unsigned            mirror_base    = FRAME_WORDS;
    logic                   mirror_final   = 1'b1;
    logic                   mirror_discard = 1'b0;
    logic [LIMIT_BITS-1:0]  mirror_limit   = vmosf_pkg::LIMIT_RESET;

    t_stack_res             pending_results [$];
    int                     error_count = 0;

    vm_operand_stack_with_frames #(
        .STORE_WORDS (STORE_WORDS),
        .FRAME_WORDS (FRAME_WORDS),
        .WORD_BITS   (WORD_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_value          (i_value),
        .i_count          (i_count),
        .i_flag_value     (i_flag_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found          (o_found),
        .o_entry_address  (o_entry_address),
        .o_final_flag     (o_final_flag),
        .o_discard_flag   (o_discard_flag)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("vm_operand_stack_with_frames: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // Apply one request to the model and return the result it must give.
    function automatic t_stack_res advance_stack(input t_stack_req rq);
        t_stack_res           rs;
        int unsigned          lim;
        int unsigned          len;
        int unsigned          cnt;
        int unsigned          hdr;
        int unsigned          nb;
        logic [WORD_BITS-1:0] w;
        rs     = '0;
        rs.status = vmosf_pkg::ST_OK;
        cnt    = 32'(rq.count);
        lim    = (mirror_limit < STORE_WORDS) ? mirror_limit : STORE_WORDS;
        len    = (mirror_top + 1 >= mirror_base) ? mirror_top + 1 - mirror_base : 0;
        case (rq.cmd)
            vmosf_pkg::CMD_PUSH: begin
                if (mirror_top + 1 >= lim) begin
                    rs.status = vmosf_pkg::ST_OVER;
                end else begin
                    mirror_top++;
                    mirror_words[mirror_top] = rq.value;
                end
            end
            vmosf_pkg::CMD_POP: begin
                if (len == 0) begin
                    rs.status = vmosf_pkg::ST_UNDER;
                end else begin
                    rs.read_value = mirror_words[mirror_top];
                    mirror_top--;
                end
            end
            vmosf_pkg::CMD_PEEK: begin
                if (len != 0) begin
                    rs.found      = 1'b1;
                    rs.read_value = mirror_words[mirror_top];
                end
            end
            vmosf_pkg::CMD_SET_TOP: begin
                if (len == 0) begin
                    rs.status = vmosf_pkg::ST_UNDER;
                end else begin
                    mirror_words[mirror_top] = rq.value;
                end
            end
            vmosf_pkg::CMD_DUP: begin
                // A single-entry dup checks underflow first, any other count overflow first.
                if (cnt == 1) begin
                    if (len == 0) begin
                        rs.status = vmosf_pkg::ST_UNDER;
                    end else if (mirror_top + 1 >= lim) begin
                        rs.status = vmosf_pkg::ST_OVER;
                    end else begin
                        mirror_words[mirror_top + 1] = mirror_words[mirror_top];
                        mirror_top++;
                    end
                end else if (mirror_top + cnt >= lim) begin
                    rs.status = vmosf_pkg::ST_OVER;
                end else if (len < cnt) begin
                    rs.status = vmosf_pkg::ST_UNDER;
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        mirror_words[mirror_top + 1 + i] = mirror_words[mirror_top + 1 - cnt + i];
                    end
                    mirror_top += cnt;
                end
            end
            vmosf_pkg::CMD_DISCARD: begin
                if (len < cnt) begin
                    rs.status = vmosf_pkg::ST_UNDER;
                end else begin
                    mirror_top -= cnt;
                end
            end
            vmosf_pkg::CMD_ADDRESS: begin
                if (len < cnt) begin
                    rs.status = vmosf_pkg::ST_UNDER;
                end else begin
                    rs.entry_address = COUNT_BITS'(mirror_top + 1 - cnt);
                end
            end
            vmosf_pkg::CMD_FPUSH: begin
                hdr = mirror_top + 1;
                nb  = hdr + FRAME_WORDS;
                if (hdr >= lim || nb >= lim) begin
                    rs.status = vmosf_pkg::ST_OVER;
                end else begin
                    // Header word: caller base above the two flag bits.
                    mirror_words[hdr] = (WORD_BITS'(mirror_base) << 2)
                                      | {mirror_discard, mirror_final};
                    mirror_base    = nb;
                    mirror_top     = nb - 1;
                    mirror_final   = 1'b0;
                    mirror_discard = 1'b0;
                end
            end
            vmosf_pkg::CMD_FPOP: begin
                if (mirror_base <= FRAME_WORDS) begin
                    rs.status = vmosf_pkg::ST_UNDER;
                end else begin
                    hdr               = mirror_base - FRAME_WORDS;
                    w                 = mirror_words[hdr];
                    mirror_words[hdr] = '0;
                    mirror_top        = hdr - 1;
                    mirror_base       = (w >> 2) & 32'hFFFF;
                    mirror_final      = w[0];
                    mirror_discard    = w[1];
                end
            end
            vmosf_pkg::CMD_SET_FIN:  mirror_final   = rq.flag;
            vmosf_pkg::CMD_SET_DISC: mirror_discard = rq.flag;
            default: ;
        endcase
        rs.final_flag   = mirror_final;
        rs.discard_flag = mirror_discard;
        return rs;
    endfunction

    // Draw a request; counts lean on the current frame depth so that both
    // sides of every underflow check get exercised.
    function automatic t_stack_req random_request();
        t_stack_req  rq;
        int unsigned pick;
        int unsigned len;
        int unsigned span;
        len  = (mirror_top + 1 >= mirror_base) ? mirror_top + 1 - mirror_base : 0;
        span = (len + 1 > 1024) ? 1024 : len + 1;
        pick = $urandom_range(0, 99);
        if (pick < 24) begin
            rq.cmd = vmosf_pkg::CMD_PUSH;
        end else if (pick < 34) begin
            rq.cmd = vmosf_pkg::CMD_POP;
        end else if (pick < 41) begin
            rq.cmd = vmosf_pkg::CMD_PEEK;
        end else if (pick < 47) begin
            rq.cmd = vmosf_pkg::CMD_SET_TOP;
        end else if (pick < 56) begin
            rq.cmd = vmosf_pkg::CMD_DUP;
        end else if (pick < 62) begin
            rq.cmd = vmosf_pkg::CMD_DISCARD;
        end else if (pick < 69) begin
            rq.cmd = vmosf_pkg::CMD_ADDRESS;
        end else if (pick < 79) begin
            rq.cmd = vmosf_pkg::CMD_FPUSH;
        end else if (pick < 88) begin
            rq.cmd = vmosf_pkg::CMD_FPOP;
        end else if (pick < 94) begin
            rq.cmd = vmosf_pkg::CMD_SET_FIN;
        end else begin
            rq.cmd = vmosf_pkg::CMD_SET_DISC;
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            rq.value = '0;
        end else if (pick < 20) begin
            rq.value = '1;
        end else begin
            rq.value = $urandom;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            rq.count = COUNT_BITS'($urandom_range(0, 3));
        end else if (pick < 85) begin
            rq.count = COUNT_BITS'($urandom_range(0, span));
        end else if (pick < 95) begin
            rq.count = COUNT_BITS'($urandom_range(0, 1024));
        end else begin
            rq.count = 11'd1024;
        end
        rq.flag = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    // Present a request, hold it until taken, then drop start and idle for the gap.
    // With no gap start stays high for the next request.
    task automatic send_request(input t_stack_req rq, input logic fixed,
                                input t_stack_res fixed_res, input int gap);
        t_stack_res want;
        start        <= 1'b1;
        i_command    <= rq.cmd;
        i_value      <= rq.value;
        i_count      <= rq.count;
        i_flag_value <= rq.flag;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = advance_stack(rq);
        pending_results.push_back(fixed ? fixed_res : want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] lim);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        mirror_limit = lim;
        i_cfg_we    <= 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_stack_res want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                end
                if (o_read_value !== want.read_value) begin
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              o_read_value, want.read_value));
                end
                if (o_found !== want.found) begin
                    report_mismatch($sformatf("found %b, expected %b",
                                              o_found, want.found));
                end
                if (o_entry_address !== want.entry_address) begin
                    report_mismatch($sformatf("entry_address %0d, expected %0d",
                                              o_entry_address, want.entry_address));
                end
                if (o_final_flag !== want.final_flag) begin
                    report_mismatch($sformatf("final_flag %b, expected %b",
                                              o_final_flag, want.final_flag));
                end
                if (o_discard_flag !== want.discard_flag) begin
                    report_mismatch($sformatf("discard_flag %b, expected %b",
                                              o_discard_flag, want.discard_flag));
                end
            end
        end
    end

    initial begin : stimulus
        logic [LIMIT_BITS-1:0] phase_limit;
        int                    gap;
        bit                    calm;
        bit                    pause;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            gap = (k == DIR_ROWS - 1) ? 1 : $urandom_range(0, 7);
            send_request(DIRECTED[k].rq, DIRECTED[k].fixed, DIRECTED[k].res, gap);
        end

        // Each phase starts idle; the stack carries over, so a lowered limit
        // may sit below the current top.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       phase_limit = 11'd1024;
                1:       phase_limit = 11'd5;
                2:       phase_limit = 11'd24;
                3:       phase_limit = 11'h7FF;
                4:       phase_limit = LIMIT_BITS'($urandom_range(5, 1024));
                default: phase_limit = 11'd1024;
            endcase
            write_limit(phase_limit);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % 32 == 0) begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                gap   = calm ? 0 : $urandom_range(0, 7);
                pause = ($urandom_range(0, 59) == 0);
                // Drop start after the last request and before any pause.
                if ((pause || n == PHASE_REQUESTS - 1) && gap == 0) begin
                    gap = 1;
                end
                send_request(random_request(), 1'b0, '0, gap);
                if (pause) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("vm_operand_stack_with_frames: match");
        end else begin
            $display("vm_operand_stack_with_frames: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/vmosf_pkg.sv
rtl/vm_operand_stack_with_frames.sv
dv/vm_operand_stack_with_frames_tb.sv
